@@ rtl/frequency_ordered_list_locate_core_macros.svh @@
// Assertion macros shared by the frequency-ordered list locate core.
// Included by the RTL file that carries concurrent checks; no other dependencies.
`ifndef FREQUENCY_ORDERED_LIST_LOCATE_CORE_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_LOCATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define FOL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// A condition that implies another in the same cycle.
`define FOL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// A condition that implies another in the next cycle.
`define FOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FOL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define FOL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define FOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/fol_pkg.sv @@
// Package for the frequency-ordered list locate core: widths, request codes, cell control.
// No dependencies; used by fol_cell and frequency_ordered_list_locate_core.
`timescale 1ns / 1ps

package fol_pkg;

    localparam int FOL_ENTRIES    = 16;
    localparam int FOL_COUNT_BITS = 16;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int OUT_COUNT_W = 16;

    localparam int S_TDATA_W = ((POS_W + 2 * VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((POS_W + OUT_COUNT_W + 7) / 8) * 8;

    typedef enum logic {
        REQ_LOCATE = 1'b0,
        REQ_LOAD   = 1'b1
    } fol_req_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic               accept_locate;
        logic               accept_load;
        logic               move_en;
        logic [POS_W-1:0]   load_position;
        logic [VALUE_W-1:0] load_value;
        logic [VALUE_W-1:0] search_key;
        logic [VALUE_W-1:0] move_key;
    } fol_ctrl_t;

endpackage

@@ rtl/fol_cell.sv @@
// One list cell: holds a value and its access count, compares, and shifts from its neighbour.
// Depends on fol_pkg.
`timescale 1ns / 1ps

module fol_cell import fol_pkg::*; #(
    parameter int IDX        = 0,
    parameter int COUNT_BITS = FOL_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fol_ctrl_t             ctrl,
    input  logic [COUNT_BITS-1:0] old_count,
    input  logic [COUNT_BITS-1:0] inc_count,
    input  logic                  seen_in,
    output logic                  seen_out,
    output logic [COUNT_BITS-1:0] sel_count,
    output logic                  hit,
    input  logic [VALUE_W-1:0]    left_value,
    input  logic [COUNT_BITS-1:0] left_count,
    input  logic                  left_run,
    output logic [VALUE_W-1:0]    value_out,
    output logic [COUNT_BITS-1:0] count_out,
    input  logic                  run_in,
    output logic                  run_out,
    output logic                  start
);

    logic [VALUE_W-1:0]    value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  hit_reg;
    logic                  match;
    logic                  first;
    logic                  load_hit;

    assign match     = (value_reg == ctrl.search_key);
    assign first     = match && !seen_in;
    assign seen_out  = seen_in || match;
    assign sel_count = first ? count_reg : '0;
    assign load_hit  = ctrl.accept_load
                       && (VALUE_W'(ctrl.load_position) == VALUE_W'(IDX));

    // The run is the stretch ending at the hit cell whose counts equal the old count.
    assign run_out   = hit_reg || ((count_reg == old_count) && run_in);
    assign start     = run_out && !left_run;

    assign hit       = hit_reg;
    assign value_out = value_reg;
    assign count_out = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= VALUE_W'(IDX);
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctrl.accept_locate || ctrl.accept_load) begin
                hit_reg <= ctrl.accept_locate && first;
            end
            if (load_hit) begin
                value_reg <= ctrl.load_value;
                count_reg <= '0;
            end else if (ctrl.move_en && start) begin
                value_reg <= ctrl.move_key;
                count_reg <= inc_count;
            end else if (ctrl.move_en && run_out) begin
                value_reg <= left_value;
                count_reg <= left_count;
            end
        end
    end

endmodule

@@ rtl/frequency_ordered_list_locate_core.sv @@
// Top level of the frequency-ordered list locate core: controller, result register, cell row.
// Depends on fol_pkg, fol_cell and frequency_ordered_list_locate_core_macros.svh.
`timescale 1ns / 1ps
`include "frequency_ordered_list_locate_core_macros.svh"

// Channel   Direction  tdata (lowest bit up)                          tuser
// s_        in         load_position[3:0], load_value, search_key     req_type
// m_        out        new_position[3:0], new_count[15:0]             found
//
// Every item passes through the transfer cycle, in which each cell compares its value with
// the key and the front-most match is found along the row, and the FINISH state, in which
// the run ending at the hit cell is resolved along the row and every cell in it shifts once.
// The FINISH state waits while the result register still holds an untaken result; the list
// is not touched until the result can be written, so a stall on the output side is harmless.
// A new transfer is accepted whenever the controller is idle and out of reset, even if a
// result is waiting. Reset (aresetn low, synchronous) loads cell i with the value i and a
// zero count, and holds s_tready low.

module frequency_ordered_list_locate_core import fol_pkg::*; #(
    parameter int ENTRIES    = FOL_ENTRIES,
    parameter int COUNT_BITS = FOL_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // load_position, load_value, search_key, zero pad
    input  logic                 s_tuser,  // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // new_position, new_count, zero pad
    output logic                 m_tuser   // found
);

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW       = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic {
        IDLE,
        FINISH
    } state_t;

    state_t                  state_reg;
    logic                    found_reg;
    logic [COUNT_BITS-1:0]   oldc_reg;
    logic [VALUE_W-1:0]      key_reg;
    logic                    m_tvalid_reg;
    logic                    m_found_reg;
    logic [POS_W-1:0]        m_pos_reg;
    logic [OUT_COUNT_W-1:0]  m_count_reg;

    fol_ctrl_t               ctrl;
    logic                    accept;
    logic                    move_fire;
    logic [COUNT_BITS-1:0]   newc;
    logic [COUNT_BITS-1:0]   sel_or;
    logic [PW-1:0]           start_pos;

    // Neighbour chains along the row; the extra element closes each end.
    logic                    seen   [0:ENTRIES];
    logic                    run    [0:ENTRIES];
    logic [VALUE_W-1:0]      values [0:ENTRIES-1];
    logic [COUNT_BITS-1:0]   counts [0:ENTRIES-1];
    logic [COUNT_BITS-1:0]   sels   [0:ENTRIES-1];
    logic [ENTRIES-1:0]      hit_vec;
    logic [ENTRIES-1:0]      start_vec;

    assign s_tready = aresetn && (state_reg == IDLE);
    assign accept   = s_tvalid && s_tready;

    // The result register can be written when it is empty or is being emptied now.
    assign move_fire = (state_reg == FINISH) && (!m_tvalid_reg || m_tready);

    assign ctrl.accept_locate = accept && (fol_req_t'(s_tuser) == REQ_LOCATE);
    assign ctrl.accept_load   = accept && (fol_req_t'(s_tuser) == REQ_LOAD);
    assign ctrl.move_en       = move_fire;
    assign ctrl.load_position = s_tdata[POS_W-1:0];
    assign ctrl.load_value    = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign ctrl.search_key    = s_tdata[POS_W+2*VALUE_W-1:POS_W+VALUE_W];
    assign ctrl.move_key      = key_reg;

    // A saturated count stays put, but the entry still moves to the head of its run.
    assign newc = (oldc_reg == COUNT_MAX) ? COUNT_MAX : oldc_reg + 1'b1;

    assign seen[0]       = 1'b0;
    assign run[ENTRIES]  = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [VALUE_W-1:0]    left_value;
        logic [COUNT_BITS-1:0] left_count;
        logic                  left_run;

        if (i == 0) begin : g_head
            assign left_value = '0;
            assign left_count = '0;
            assign left_run   = 1'b0;
        end else begin : g_body
            assign left_value = values[i-1];
            assign left_count = counts[i-1];
            assign left_run   = run[i-1];
        end

        fol_cell #(
            .IDX        (i),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .old_count  (oldc_reg),
            .inc_count  (newc),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .sel_count  (sels[i]),
            .hit        (hit_vec[i]),
            .left_value (left_value),
            .left_count (left_count),
            .left_run   (left_run),
            .value_out  (values[i]),
            .count_out  (counts[i]),
            .run_in     (run[i+1]),
            .run_out    (run[i]),
            .start      (start_vec[i])
        );
    end

    // Only the front-most matching cell drives its count, so an OR picks it out.
    always_comb begin
        sel_or = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            sel_or = sel_or | sels[i];
        end
    end

    // Exactly one cell marks the start of the run when the locate hit.
    always_comb begin
        start_pos = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (start_vec[i]) begin
                start_pos = start_pos | PW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            // A new result replaces the one being taken in the same cycle.
            if (move_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        found_reg <= ctrl.accept_locate && seen[ENTRIES];
                        oldc_reg  <= sel_or;
                        key_reg   <= ctrl.search_key;
                        state_reg <= FINISH;
                    end
                end
                FINISH: begin
                    if (move_fire) begin
                        m_found_reg  <= found_reg;
                        m_pos_reg    <= found_reg ? start_pos[POS_W-1:0] : '0;
                        m_count_reg  <= found_reg ? OUT_COUNT_W'(newc) : '0;
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_pos_reg});

    // Checks on the cell row and the controller.
    `FOL_ASSERT_ALWAYS(a_hit_onehot0, aclk, aresetn, $onehot0(hit_vec),
        "more than one cell holds the hit mark")
    `FOL_ASSERT_SAME(a_start_onehot, aclk, aresetn, move_fire && found_reg,
        $onehot(start_vec), "a located entry must have exactly one run start")
    `FOL_ASSERT_SAME(a_miss_no_hit, aclk, aresetn, (state_reg == FINISH) && !found_reg,
        hit_vec == '0, "a miss or a load left a hit mark in the row")
    `FOL_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "a second transfer was accepted before the first finished")
    `FOL_ASSERT_NEXT(a_result_written, aclk, aresetn, move_fire,
        m_tvalid && (m_tuser == $past(found_reg)), "result register not loaded on finish")

endmodule

@@ test/frequency_ordered_list_locate_core_tb.sv @@
// Self-checking testbench for the frequency-ordered list locate core: directed and random
// traffic with a predicting scoreboard class and random stalls on both sides.
// Depends on fol_pkg and frequency_ordered_list_locate_core.
`timescale 1ns / 1ps

module frequency_ordered_list_locate_core_tb import fol_pkg::*;;

    localparam int ENTRIES      = FOL_ENTRIES;
    localparam int COUNT_BITS   = FOL_COUNT_BITS;
    localparam int RANDOM_ITEMS = 620;
    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 1000;

    typedef struct {
        bit                   found;
        bit [POS_W-1:0]       position;
        bit [OUT_COUNT_W-1:0] count;
    } locate_result_t;

    // Scoreboard: keeps its own copy of the list, predicts the result of every accepted
    // transfer and compares each result transfer with the oldest prediction.
    class freq_list_scoreboard;
        bit [VALUE_W-1:0]    entry_value[ENTRIES];
        bit [COUNT_BITS-1:0] entry_count[ENTRIES];
        locate_result_t      pending_results[$];
        int                  errors;
        int                  results_seen;

        function new();
            for (int k = 0; k < ENTRIES; k++) begin
                entry_value[k] = k;
                entry_count[k] = '0;
            end
            errors       = 0;
            results_seen = 0;
        endfunction

        function void record_request(logic [S_TDATA_W-1:0] word, logic kind);
            bit [POS_W-1:0]      pos;
            bit [VALUE_W-1:0]    value;
            bit [VALUE_W-1:0]    key;
            bit [COUNT_BITS-1:0] old_count;
            bit [COUNT_BITS-1:0] new_count;
            locate_result_t      want;
            int                  hit;
            int                  head;

            pos   = word[POS_W-1:0];
            value = word[POS_W +: VALUE_W];
            key   = word[POS_W + VALUE_W +: VALUE_W];
            want  = '{found: 1'b0, position: '0, count: '0};

            if (fol_req_t'(kind) == REQ_LOAD) begin
                if (pos < ENTRIES) begin
                    entry_value[pos] = value;
                    entry_count[pos] = '0;
                end
            end else begin
                hit = -1;
                for (int k = 0; k < ENTRIES; k++) begin
                    if (hit < 0 && entry_value[k] == key) hit = k;
                end
                if (hit >= 0) begin
                    old_count = entry_count[hit];
                    new_count = (old_count == '1) ? old_count : old_count + 1'b1;
                    // The entry moves to the front of the unbroken stretch of equal counts
                    // that ends at it, which for a sorted list is just behind the larger ones.
                    head = hit;
                    while (head > 0 && entry_count[head-1] == old_count) head--;
                    for (int k = hit; k > head; k--) begin
                        entry_value[k] = entry_value[k-1];
                        entry_count[k] = entry_count[k-1];
                    end
                    entry_value[head] = key;
                    entry_count[head] = new_count;
                    want.found    = 1'b1;
                    want.position = head[POS_W-1:0];
                    want.count    = new_count[OUT_COUNT_W-1:0];
                end
            end
            pending_results.push_back(want);
        endfunction

        function void compare_result(logic [M_TDATA_W-1:0] word, logic flag);
            locate_result_t want;

            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: found %0d position %0d count %0d",
                         $time, flag, word[POS_W-1:0], word[POS_W +: OUT_COUNT_W]);
                return;
            end
            want = pending_results.pop_front();
            if (flag !== want.found) begin
                errors++;
                $display("%0t: found mismatch: expected %0d, actual %0d",
                         $time, want.found, flag);
            end
            if (word[POS_W-1:0] !== want.position) begin
                errors++;
                $display("%0t: new_position mismatch: expected %0d, actual %0d",
                         $time, want.position, word[POS_W-1:0]);
            end
            if (word[POS_W +: OUT_COUNT_W] !== want.count) begin
                errors++;
                $display("%0t: new_count mismatch: expected %0d, actual %0d",
                         $time, want.count, word[POS_W +: OUT_COUNT_W]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // load_position, load_value, search_key, zero pad
    logic                 s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // new_position, new_count, zero pad
    logic                 m_tuser;   // found

    freq_list_scoreboard list_sb = new();

    // Set for the last 15 of every 100 random items so that both sides run back to back; otherwise
    // every transfer is preceded by a random gap.
    bit no_gaps = 1'b0;
    int idle_cycles = 0;

    frequency_ordered_list_locate_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // All inputs are known from time zero; reset is held low at the start only.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Both channels are observed at the rising edge. Predictions are made here, so by the
    // following falling edge the scoreboard's list already reflects every accepted request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) list_sb.record_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) list_sb.compare_result(m_tdata, m_tuser);
        end
    end

    // Watchdog: a run of cycles with no transfer on either side means the block has hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("frequency_ordered_list_locate_core_tb: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side. Each result is preceded by a random hold-off; once, after enough results
    // have gone by, the receiver refuses everything for a long stretch so that the result
    // register fills, the controller backs up and s_tready falls while requests are offered.
    initial begin : result_sink
        int gap;
        bit long_stall_done;

        long_stall_done = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!long_stall_done && list_sb.results_seen >= 150) begin
                long_stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    // Offers one request after a random gap and returns at the falling edge after its
    // transfer. s_tvalid is left high, so back-to-back requests never drop it.
    task automatic send_request(fol_req_t kind, bit [POS_W-1:0] pos,
                                bit [VALUE_W-1:0] value, bit [VALUE_W-1:0] key);
        int gap;
        logic [S_TDATA_W-1:0] word;

        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        word = '0;
        word[POS_W-1:0]                 = pos;
        word[POS_W +: VALUE_W]          = value;
        word[POS_W + VALUE_W +: VALUE_W] = key;
        s_tdata  <= word;
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    // The fields a request does not use still carry random bits.
    task automatic send_locate(bit [VALUE_W-1:0] key);
        send_request(REQ_LOCATE, POS_W'($urandom_range(0, 15)), $urandom, key);
    endtask

    task automatic send_load(bit [POS_W-1:0] pos, bit [VALUE_W-1:0] value);
        send_request(REQ_LOAD, pos, value, $urandom);
    endtask

    initial begin : stimulus
        int pick;
        int slot;

        wait (aresetn === 1'b1);
        @(negedge aclk);

        // Directed part: the reset list, a hit at either end, a miss, extreme values at both
        // end positions, a duplicated value and a load that breaks the ordering.
        send_locate(32'd0);
        send_locate(32'd15);
        send_locate(32'd7);
        send_locate(32'h8000_0000);
        send_load(4'd0, 32'h7FFF_FFFF);
        send_load(4'd15, 32'h8000_0000);
        send_locate(32'h7FFF_FFFF);
        send_locate(32'h8000_0000);
        send_locate(32'h8000_0000);
        send_load(4'd4, 32'hFFFF_FFFF);
        send_load(4'd9, 32'hFFFF_FFFF);
        send_locate(32'hFFFF_FFFF);
        send_locate(32'hFFFF_FFFF);
        send_locate(32'hFFFF_FFFF);
        send_locate(32'd0);
        send_load(4'd2, 32'h5555_5555);
        send_locate(32'hAAAA_AAAA);
        send_load(4'd3, 32'hAAAA_AAAA);
        send_locate(32'hAAAA_AAAA);
        send_locate(32'h5555_5555);

        // Random part. Most requests locate a value that is in the list, biased towards the
        // front so that counts grow and ties form; the rest are misses, loads of random or
        // small values, and loads that duplicate a value already present.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = (n % 100) >= 85;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
                send_locate(list_sb.entry_value[slot]);
            end else if (pick < 77) begin
                send_locate($urandom);
            end else if (pick < 87) begin
                send_load(POS_W'($urandom_range(0, 15)), $urandom);
            end else if (pick < 93) begin
                send_load(POS_W'($urandom_range(0, 15)), $urandom_range(0, 20));
            end else begin
                send_load(POS_W'($urandom_range(0, 15)),
                          list_sb.entry_value[$urandom_range(0, 15)]);
            end
        end
        no_gaps = 1'b0;

        for (int n = 0; n < 10; n++) begin
            send_locate(list_sb.entry_value[$urandom_range(0, 15)]);
        end
        s_tvalid <= 1'b0;

        // Drain: the watchdog bounds this wait should a result never appear.
        while (list_sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (list_sb.errors == 0) begin
            $display("frequency_ordered_list_locate_core_tb: done, clean");
        end else begin
            $display("frequency_ordered_list_locate_core_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fol_pkg.sv
rtl/fol_cell.sv
rtl/frequency_ordered_list_locate_core.sv
test/frequency_ordered_list_locate_core_tb.sv
